>>> hdl/tspm_pkg.sv
// tspm_pkg: shared types, codes and helpers of the timestamp pair merger
// no dependencies
`default_nettype none

package tspm_pkg;

    localparam int STAMP_W = 63;
    localparam int DIST_W  = 16;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 8;
    localparam int OP_W    = 64;

    // one stored reading
    typedef struct packed {
        logic [STAMP_W-1:0]       stamp;
        logic signed [DIST_W-1:0] left;
        logic signed [DIST_W-1:0] right;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // item kinds
    localparam logic [1:0] KIND_CAMERA = 2'd0;
    localparam logic [1:0] KIND_LIDAR  = 2'd1;
    localparam logic [1:0] KIND_MATCH  = 2'd2;

    // result status codes
    localparam logic [2:0] STATUS_STORED   = 3'd0;
    localparam logic [2:0] STATUS_FULL     = 3'd1;
    localparam logic [2:0] STATUS_EMPTY    = 3'd2;
    localparam logic [2:0] STATUS_NO_MATCH = 3'd3;
    localparam logic [2:0] STATUS_MERGED   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD_AGE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW = 8'd1;

    localparam logic [CFG_W-1:0] DISCARD_AGE_RST  = 40'd500000000;
    localparam logic [CFG_W-1:0] MATCH_WINDOW_RST = 40'd50000000;

    // average of present distances, 0 when neither is present
    function automatic logic signed [DIST_W-1:0] merge_dist(
        input logic signed [DIST_W-1:0] a,
        input logic signed [DIST_W-1:0] b
    );
        logic [DIST_W:0] sum;
        logic [DIST_W-1:0] res;
        sum = {1'b0, a} + {1'b0, b};
        if (a > 0 && b > 0) begin
            res = sum[DIST_W:1];
        end else if (a > 0) begin
            res = a;
        end else if (b > 0) begin
            res = b;
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hdl/tspm_ram.sv
// tspm_ram: generic single write, single read RAM with registered read
// no dependencies
`default_nettype none

module tspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> hdl/tspm_sub.sv
// tspm_sub: shared subtract and compare unit used by the sequencer
// depends on tspm_pkg
`default_nettype none

module tspm_sub (
    input  wire logic [tspm_pkg::OP_W-1:0] op_a,
    input  wire logic [tspm_pkg::OP_W-1:0] op_b,
    output logic                           lt,
    output logic [tspm_pkg::OP_W-1:0]      diff
);
    import tspm_pkg::*;

    logic [OP_W:0] full;

    // one wide subtract gives both difference and a < b
    assign full = {1'b0, op_a} - {1'b0, op_b};
    assign lt   = full[OP_W];
    assign diff = full[OP_W-1:0];

endmodule

`default_nettype wire

>>> hdl/two_sensor_timestamp_pair_merger_core.sv
// two_sensor_timestamp_pair_merger_core: top level, sequencer and stores
// depends on tspm_pkg, tspm_ram, tspm_sub
//
//  channel  | direction | ports
//  ---------+-----------+-----------------------------------------------------
//  s_       | in        | s_valid s_ready s_kind s_stamp s_left_dist s_right_dist
//  m_       | out       | m_valid m_ready m_status m_merged_stamp m_merged_left/right
//  cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data
//
// an insert or unused kind goes from the idle state straight to the final state;
// a match walks the stores entry by entry through the single read port of each
// store and the one shared subtract unit; one item is in work at a time
// reset clears state, counts, output valid and configuration registers;
// datapath registers and stores hold no reset value
// a result waiting on m_ready holds the sequencer in its final state
`default_nettype none

module two_sensor_timestamp_pair_merger_core #(
    parameter int STORE_DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [1:0]                            s_kind,
    input  wire logic [tspm_pkg::STAMP_W-1:0]          s_stamp,
    input  wire logic signed [tspm_pkg::DIST_W-1:0]    s_left_dist,
    input  wire logic signed [tspm_pkg::DIST_W-1:0]    s_right_dist,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [2:0]                                 m_status,
    output logic [tspm_pkg::STAMP_W-1:0]               m_merged_stamp,
    output logic signed [tspm_pkg::DIST_W-1:0]         m_merged_left,
    output logic signed [tspm_pkg::DIST_W-1:0]         m_merged_right,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tspm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tspm_pkg::CFG_W-1:0]            cfg_data
);
    import tspm_pkg::*;

    localparam int IW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_NEW_RD  = 17'h00002,
        ST_NEW_CMP = 17'h00004,
        ST_PR_RD   = 17'h00008,
        ST_PR_SUB  = 17'h00010,
        ST_PR_CMP  = 17'h00020,
        ST_OL_RD   = 17'h00040,
        ST_OL_CMP  = 17'h00080,
        ST_REF     = 17'h00100,
        ST_SR_RD   = 17'h00200,
        ST_SR_LT   = 17'h00400,
        ST_SR_DIF  = 17'h00800,
        ST_SR_CMP  = 17'h01000,
        ST_RM_RD   = 17'h02000,
        ST_RM_WR   = 17'h04000,
        ST_MERGE   = 17'h08000,
        ST_FIN     = 17'h10000
    } state_t;

    // control registers
    state_t state_reg, state_next;
    logic [CW-1:0] cam_cnt_reg, cam_cnt_next, lid_cnt_reg, lid_cnt_next;
    logic m_valid_reg, m_valid_next;
    logic [CFG_W-1:0] age_reg, age_next, window_reg, window_next;

    // datapath registers
    logic [CW-1:0] i_reg, i_next, k_reg, k_next;
    logic which_reg, which_next, rwhich_reg, rwhich_next, rm_pass_reg, rm_pass_next;
    logic lt_reg, lt_next;
    logic [STAMP_W-1:0] newest_reg, newest_next, diff_reg, diff_next;
    entry_t ent_reg, ent_next, best_reg, best_next, cbest_reg, cbest_next;
    entry_t ref_reg, ref_next, oth_reg, oth_next;
    logic [IW-1:0] bidx_reg, bidx_next, cidx_reg, cidx_next, oidx_reg, oidx_next;
    logic [2:0] res_status_reg, res_status_next;
    logic [STAMP_W-1:0] res_stamp_reg, res_stamp_next;
    logic signed [DIST_W-1:0] res_left_reg, res_left_next, res_right_reg, res_right_next;
    logic [2:0] m_status_reg, m_status_next;
    logic [STAMP_W-1:0] m_stamp_reg, m_stamp_next;
    logic signed [DIST_W-1:0] m_left_reg, m_left_next, m_right_reg, m_right_next;

    // store ports and shared unit
    logic cam_we, lid_we;
    logic [IW-1:0] wr_addr, rd_addr;
    entry_t wr_data, cam_rd, lid_rd, rd_ent;
    logic [OP_W-1:0] op_a, op_b, sub_diff;
    logic sub_lt;
    logic [CW-1:0] cnt_sel, i_inc;
    logic [STAMP_W:0] stamp_sum;
    entry_t in_ent;

    tspm_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_cam_ram (
        .aclk(aclk), .we(cam_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(cam_rd)
    );

    tspm_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_lid_ram (
        .aclk(aclk), .we(lid_we), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(lid_rd)
    );

    tspm_sub u_sub (.op_a(op_a), .op_b(op_b), .lt(sub_lt), .diff(sub_diff));

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_merged_stamp = m_stamp_reg;
    assign m_merged_left  = m_left_reg;
    assign m_merged_right = m_right_reg;

    assign rd_ent    = which_reg ? lid_rd : cam_rd;
    assign cnt_sel   = which_reg ? lid_cnt_reg : cam_cnt_reg;
    assign i_inc     = i_reg + CW'(1);
    assign stamp_sum = {1'b0, ref_reg.stamp} + {1'b0, oth_reg.stamp};
    assign in_ent    = '{stamp: s_stamp, left: s_left_dist, right: s_right_dist};

    // shared unit operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_NEW_CMP, ST_PR_SUB: begin
                op_a = {1'b0, newest_reg};
                op_b = {1'b0, rd_ent.stamp};
            end
            ST_PR_CMP: begin
                op_a = {1'b0, diff_reg};
                op_b = OP_W'(age_reg);
            end
            ST_OL_CMP: begin
                op_a = {1'b0, rd_ent.stamp};
                op_b = {1'b0, best_reg.stamp};
            end
            ST_REF: begin
                op_a = {1'b0, cbest_reg.stamp};
                op_b = {1'b0, best_reg.stamp};
            end
            ST_SR_LT: begin
                op_a = {1'b0, ref_reg.stamp};
                op_b = {1'b0, rd_ent.stamp};
            end
            ST_SR_DIF: begin
                op_a = {1'b0, lt_reg ? ent_reg.stamp : ref_reg.stamp};
                op_b = {1'b0, lt_reg ? ref_reg.stamp : ent_reg.stamp};
            end
            ST_SR_CMP: begin
                op_a = {1'b0, diff_reg};
                op_b = OP_W'(window_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cam_cnt_next    = cam_cnt_reg;
        lid_cnt_next    = lid_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        age_next        = age_reg;
        window_next     = window_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        which_next      = which_reg;
        rwhich_next     = rwhich_reg;
        rm_pass_next    = rm_pass_reg;
        lt_next         = lt_reg;
        newest_next     = newest_reg;
        diff_next       = diff_reg;
        ent_next        = ent_reg;
        best_next       = best_reg;
        cbest_next      = cbest_reg;
        ref_next        = ref_reg;
        oth_next        = oth_reg;
        bidx_next       = bidx_reg;
        cidx_next       = cidx_reg;
        oidx_next       = oidx_reg;
        res_status_next = res_status_reg;
        res_stamp_next  = res_stamp_reg;
        res_left_next   = res_left_reg;
        res_right_next  = res_right_reg;
        m_status_next   = m_status_reg;
        m_stamp_next    = m_stamp_reg;
        m_left_next     = m_left_reg;
        m_right_next    = m_right_reg;
        cam_we          = 1'b0;
        lid_we          = 1'b0;
        wr_addr         = k_reg[IW-1:0];
        wr_data         = ent_reg;
        rd_addr         = i_reg[IW-1:0];

        // configuration writes
        if (cfg_valid) begin
            if (cfg_index == REG_DISCARD_AGE) begin
                age_next = cfg_data;
            end else if (cfg_index == REG_MATCH_WINDOW) begin
                window_next = cfg_data;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_stamp_next = '0;
                    res_left_next  = '0;
                    res_right_next = '0;
                    state_next     = ST_FIN;
                    wr_data        = in_ent;
                    if (s_kind == KIND_CAMERA) begin
                        wr_addr = cam_cnt_reg[IW-1:0];
                        if (cam_cnt_reg >= CW'(STORE_DEPTH)) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            cam_we          = 1'b1;
                            cam_cnt_next    = cam_cnt_reg + CW'(1);
                            res_status_next = STATUS_STORED;
                        end
                    end else if (s_kind == KIND_LIDAR) begin
                        wr_addr = lid_cnt_reg[IW-1:0];
                        if (lid_cnt_reg >= CW'(STORE_DEPTH)) begin
                            res_status_next = STATUS_FULL;
                        end else begin
                            lid_we          = 1'b1;
                            lid_cnt_next    = lid_cnt_reg + CW'(1);
                            res_status_next = STATUS_STORED;
                        end
                    end else if (s_kind == KIND_MATCH) begin
                        newest_next = '0;
                        i_next      = '0;
                        which_next  = 1'b0;
                        state_next  = ST_NEW_RD;
                    end else begin
                        res_status_next = STATUS_NO_MATCH;
                    end
                end
            end
            // newest stamp over both stores
            ST_NEW_RD: begin
                if (i_reg == cnt_sel) begin
                    i_next = '0;
                    k_next = '0;
                    which_next = !which_reg;
                    if (which_reg) begin
                        state_next = ST_PR_RD;
                    end
                end else begin
                    state_next = ST_NEW_CMP;
                end
            end
            ST_NEW_CMP: begin
                if (sub_lt) begin
                    newest_next = rd_ent.stamp;
                end
                i_next     = i_inc;
                state_next = ST_NEW_RD;
            end
            // prune with in-place compaction
            ST_PR_RD: begin
                if (i_reg == cnt_sel) begin
                    i_next = '0;
                    k_next = '0;
                    if (which_reg) begin
                        lid_cnt_next = k_reg;
                        which_next   = 1'b0;
                        if (cam_cnt_reg == '0 || k_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_FIN;
                        end else begin
                            state_next = ST_OL_RD;
                        end
                    end else begin
                        cam_cnt_next = k_reg;
                        which_next   = 1'b1;
                    end
                end else begin
                    state_next = ST_PR_SUB;
                end
            end
            ST_PR_SUB: begin
                ent_next   = rd_ent;
                diff_next  = sub_diff[STAMP_W-1:0];
                state_next = ST_PR_CMP;
            end
            ST_PR_CMP: begin
                if (sub_lt) begin
                    cam_we = !which_reg;
                    lid_we = which_reg;
                    k_next = k_reg + CW'(1);
                end
                i_next     = i_inc;
                state_next = ST_PR_RD;
            end
            // oldest entry of each store
            ST_OL_RD: begin
                if (i_reg == cnt_sel) begin
                    if (which_reg) begin
                        state_next = ST_REF;
                    end else begin
                        cbest_next = best_reg;
                        cidx_next  = bidx_reg;
                        which_next = 1'b1;
                        i_next     = '0;
                    end
                end else begin
                    state_next = ST_OL_CMP;
                end
            end
            ST_OL_CMP: begin
                if (i_reg == '0 || sub_lt) begin
                    best_next = rd_ent;
                    bidx_next = i_reg[IW-1:0];
                end
                i_next     = i_inc;
                state_next = ST_OL_RD;
            end
            // reference is the camera entry only when strictly older
            ST_REF: begin
                if (sub_lt) begin
                    ref_next    = cbest_reg;
                    bidx_next   = cidx_reg;
                    rwhich_next = 1'b0;
                    which_next  = 1'b1;
                end else begin
                    ref_next    = best_reg;
                    rwhich_next = 1'b1;
                    which_next  = 1'b0;
                end
                i_next     = '0;
                state_next = ST_SR_RD;
            end
            // search the other store in order
            ST_SR_RD: begin
                if (i_reg == cnt_sel) begin
                    res_status_next = STATUS_NO_MATCH;
                    state_next      = ST_FIN;
                end else begin
                    state_next = ST_SR_LT;
                end
            end
            ST_SR_LT: begin
                ent_next   = rd_ent;
                lt_next    = sub_lt;
                state_next = ST_SR_DIF;
            end
            ST_SR_DIF: begin
                diff_next  = sub_diff[STAMP_W-1:0];
                state_next = ST_SR_CMP;
            end
            ST_SR_CMP: begin
                if (sub_lt) begin
                    oth_next     = ent_reg;
                    oidx_next    = i_reg[IW-1:0];
                    which_next   = rwhich_reg;
                    i_next       = {{(CW-IW){1'b0}}, bidx_reg};
                    rm_pass_next = 1'b0;
                    state_next   = ST_RM_RD;
                end else begin
                    i_next     = i_inc;
                    state_next = ST_SR_RD;
                end
            end
            // remove by shifting later entries down one place
            ST_RM_RD: begin
                rd_addr = i_inc[IW-1:0];
                if (i_inc >= cnt_sel) begin
                    if (which_reg) begin
                        lid_cnt_next = lid_cnt_reg - CW'(1);
                    end else begin
                        cam_cnt_next = cam_cnt_reg - CW'(1);
                    end
                    if (rm_pass_reg) begin
                        state_next = ST_MERGE;
                    end else begin
                        rm_pass_next = 1'b1;
                        which_next   = !which_reg;
                        i_next       = {{(CW-IW){1'b0}}, oidx_reg};
                    end
                end else begin
                    state_next = ST_RM_WR;
                end
            end
            ST_RM_WR: begin
                wr_addr    = i_reg[IW-1:0];
                wr_data    = rd_ent;
                cam_we     = !which_reg;
                lid_we     = which_reg;
                i_next     = i_inc;
                state_next = ST_RM_RD;
            end
            ST_MERGE: begin
                res_status_next = STATUS_MERGED;
                res_stamp_next  = stamp_sum[STAMP_W:1];
                res_left_next   = merge_dist(ref_reg.left, oth_reg.left);
                res_right_next  = merge_dist(ref_reg.right, oth_reg.right);
                state_next      = ST_FIN;
            end
            // hand the result to the output register
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_stamp_next  = res_stamp_reg;
                    m_left_next   = res_left_reg;
                    m_right_next  = res_right_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cam_cnt_reg <= '0;
            lid_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            age_reg     <= DISCARD_AGE_RST;
            window_reg  <= MATCH_WINDOW_RST;
        end else begin
            state_reg   <= state_next;
            cam_cnt_reg <= cam_cnt_next;
            lid_cnt_reg <= lid_cnt_next;
            m_valid_reg <= m_valid_next;
            age_reg     <= age_next;
            window_reg  <= window_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        k_reg          <= k_next;
        which_reg      <= which_next;
        rwhich_reg     <= rwhich_next;
        rm_pass_reg    <= rm_pass_next;
        lt_reg         <= lt_next;
        newest_reg     <= newest_next;
        diff_reg       <= diff_next;
        ent_reg        <= ent_next;
        best_reg       <= best_next;
        cbest_reg      <= cbest_next;
        ref_reg        <= ref_next;
        oth_reg        <= oth_next;
        bidx_reg       <= bidx_next;
        cidx_reg       <= cidx_next;
        oidx_reg       <= oidx_next;
        res_status_reg <= res_status_next;
        res_stamp_reg  <= res_stamp_next;
        res_left_reg   <= res_left_next;
        res_right_reg  <= res_right_next;
        m_status_reg   <= m_status_next;
        m_stamp_reg    <= m_stamp_next;
        m_left_reg     <= m_left_next;
        m_right_reg    <= m_right_next;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cam_cnt_reg <= CW'(STORE_DEPTH) && lid_cnt_reg <= CW'(STORE_DEPTH))
        else $error("store count beyond depth");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous item in work");
    a_shift_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RM_WR |-> i_inc < cnt_sel)
        else $error("removal shift past end of store");
    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PR_CMP |-> k_reg <= i_reg)
        else $error("prune write ahead of read");
`endif

endmodule

`default_nettype wire

>>> verif/tb_two_sensor_timestamp_pair_merger_core.sv
// tb_two_sensor_timestamp_pair_merger_core: self-checking bench for the pair merger core
// depends on tspm_pkg and two_sensor_timestamp_pair_merger_core; holds its own fusion predictor
`timescale 1ns / 100ps

module tb_two_sensor_timestamp_pair_merger_core;
    import tspm_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [CFG_W-1:0] CFG_MAX = 40'd1000000000000;

    typedef struct {
        logic [1:0]               kind;
        logic [STAMP_W-1:0]       stamp;
        logic signed [DIST_W-1:0] left;
        logic signed [DIST_W-1:0] right;
    } reading_item_t;

    typedef struct {
        logic [2:0]               status;
        logic [STAMP_W-1:0]       stamp;
        logic signed [DIST_W-1:0] left;
        logic signed [DIST_W-1:0] right;
    } fusion_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_kind = '0;
    logic [STAMP_W-1:0] s_stamp = '0;
    logic signed [DIST_W-1:0] s_left_dist = '0;
    logic signed [DIST_W-1:0] s_right_dist = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [2:0] m_status;
    logic [STAMP_W-1:0] m_merged_stamp;
    logic signed [DIST_W-1:0] m_merged_left;
    logic signed [DIST_W-1:0] m_merged_right;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state
    entry_t cam_buf [DEPTH];
    entry_t lid_buf [DEPTH];
    int cam_cnt = 0;
    int lid_cnt = 0;
    logic [CFG_W-1:0] age_limit = DISCARD_AGE_RST;
    logic [CFG_W-1:0] pair_window = MATCH_WINDOW_RST;

    reading_item_t pending_items[$];
    fusion_t expected_fusions[$];
    int mismatches = 0;
    logic [63:0] time_base;

    always #10 aclk = ~aclk;

    two_sensor_timestamp_pair_merger_core #(.STORE_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_stamp(s_stamp),
        .s_left_dist(s_left_dist), .s_right_dist(s_right_dist),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_merged_stamp(m_merged_stamp), .m_merged_left(m_merged_left),
        .m_merged_right(m_merged_right),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // average of present distances
    function automatic logic signed [DIST_W-1:0] fuse_dist(int a, int b);
        if (a > 0 && b > 0) return DIST_W'((a + b) / 2);
        if (a > 0) return DIST_W'(a);
        if (b > 0) return DIST_W'(b);
        return '0;
    endfunction

    // drop entries too old relative to the newest stamp
    function automatic void age_out(ref entry_t buf_q [DEPTH], ref int cnt,
                                    input logic [63:0] newest);
        int k;
        k = 0;
        for (int i = 0; i < cnt; i++) begin
            if (newest - {1'b0, buf_q[i].stamp} < {24'd0, age_limit}) begin
                buf_q[k] = buf_q[i];
                k++;
            end
        end
        cnt = k;
    endfunction

    function automatic int oldest_at(ref entry_t buf_q [DEPTH], input int cnt);
        int m;
        m = 0;
        for (int i = 1; i < cnt; i++) if (buf_q[i].stamp < buf_q[m].stamp) m = i;
        return m;
    endfunction

    function automatic void drop_at(ref entry_t buf_q [DEPTH], ref int cnt, input int idx);
        for (int i = idx; i < cnt - 1; i++) buf_q[i] = buf_q[i + 1];
        cnt--;
    endfunction

    // prune, pick the oldest reference and pair it with the other sensor
    function automatic fusion_t prune_and_pair();
        fusion_t res;
        logic [63:0] newest, diff;
        int ci, li, oi;
        entry_t ref_e, oth_e;
        logic lidar_ref;
        res = '{STATUS_EMPTY, '0, '0, '0};
        newest = '0;
        for (int i = 0; i < cam_cnt; i++) if (cam_buf[i].stamp > newest) newest = cam_buf[i].stamp;
        for (int i = 0; i < lid_cnt; i++) if (lid_buf[i].stamp > newest) newest = lid_buf[i].stamp;
        age_out(cam_buf, cam_cnt, newest);
        age_out(lid_buf, lid_cnt, newest);
        if (cam_cnt == 0 || lid_cnt == 0) return res;
        ci = oldest_at(cam_buf, cam_cnt);
        li = oldest_at(lid_buf, lid_cnt);
        lidar_ref = !(cam_buf[ci].stamp < lid_buf[li].stamp);
        ref_e = lidar_ref ? lid_buf[li] : cam_buf[ci];
        oi = -1;
        for (int i = 0; i < (lidar_ref ? cam_cnt : lid_cnt); i++) begin
            oth_e = lidar_ref ? cam_buf[i] : lid_buf[i];
            diff = (ref_e.stamp > oth_e.stamp) ? ref_e.stamp - oth_e.stamp
                                               : oth_e.stamp - ref_e.stamp;
            if (diff < {24'd0, pair_window}) begin
                oi = i;
                break;
            end
        end
        res.status = STATUS_NO_MATCH;
        if (oi < 0) return res;
        if (lidar_ref) begin
            oth_e = cam_buf[oi];
            drop_at(lid_buf, lid_cnt, li);
            drop_at(cam_buf, cam_cnt, oi);
        end else begin
            oth_e = lid_buf[oi];
            drop_at(cam_buf, cam_cnt, ci);
            drop_at(lid_buf, lid_cnt, oi);
        end
        res.status = STATUS_MERGED;
        res.stamp = STAMP_W'(({1'b0, ref_e.stamp} + {1'b0, oth_e.stamp}) >> 1);
        res.left = fuse_dist(ref_e.left, oth_e.left);
        res.right = fuse_dist(ref_e.right, oth_e.right);
        return res;
    endfunction

    function automatic fusion_t predict_fusion(reading_item_t it);
        fusion_t res;
        res = '{STATUS_NO_MATCH, '0, '0, '0};
        case (it.kind)
            KIND_CAMERA: begin
                res.status = (cam_cnt >= DEPTH) ? STATUS_FULL : STATUS_STORED;
                if (cam_cnt < DEPTH) begin
                    cam_buf[cam_cnt] = '{it.stamp, it.left, it.right};
                    cam_cnt++;
                end
            end
            KIND_LIDAR: begin
                res.status = (lid_cnt >= DEPTH) ? STATUS_FULL : STATUS_STORED;
                if (lid_cnt < DEPTH) begin
                    lid_buf[lid_cnt] = '{it.stamp, it.left, it.right};
                    lid_cnt++;
                end
            end
            KIND_MATCH: res = prune_and_pair();
            default: ;
        endcase
        return res;
    endfunction

    // driver: bursts of items separated by random gaps
    int burst_left = 4;
    int gap_left = 0;
    reading_item_t cur_item;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_fusions.insert(expected_fusions.size(), predict_fusion(cur_item));
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_kind <= cur_item.kind;
                    s_stamp <= cur_item.stamp;
                    s_left_dist <= cur_item.left;
                    s_right_dist <= cur_item.right;
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: receiver stall pattern, checking and idle watchdog
    int cyc = 0;
    int idle_cycles = 0;
    fusion_t want;
    always @(posedge aclk) begin
        cyc++;
        case (cyc[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= $urandom_range(0, 1);
            2'd2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= cyc[0];
        endcase
        if (aresetn && m_valid && m_ready) begin
            if (expected_fusions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d stamp %0d", m_status, m_merged_stamp);
            end else begin
                want = expected_fusions.pop_front();
                if (m_status !== want.status || m_merged_stamp !== want.stamp ||
                    m_merged_left !== want.left || m_merged_right !== want.right) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.status, want.stamp, want.left, want.right,
                                 m_status, m_merged_stamp, m_merged_left, m_merged_right);
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // write one register and mirror it in the predictor
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_DISCARD_AGE) age_limit = val;
        else if (idx == REG_MATCH_WINDOW) pair_window = val;
    endtask

    // hold until every item has been answered and the block is idle
    task automatic drain();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_items.size() != 0 || s_valid || expected_fusions.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic add_item(logic [1:0] k, logic [STAMP_W-1:0] st, int l, int r);
        reading_item_t it;
        it = '{k, st, l[DIST_W-1:0], r[DIST_W-1:0]};
        pending_items.insert(pending_items.size(), it);
    endtask

    // empty both stores with a zero discard age
    task automatic flush_stores();
        drain();
        write_reg(REG_DISCARD_AGE, '0);
        add_item(KIND_MATCH, '0, 0, 0);
        drain();
    endtask

    function automatic int rand_dist();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $signed($urandom_range(0, 65535) - 32768);
            2: return 32767;
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    // random items around an advancing time base
    task automatic random_phase(int n);
        logic [1:0] k;
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            k = (sel < 40) ? KIND_CAMERA : (sel < 80) ? KIND_LIDAR :
                (sel < 98) ? KIND_MATCH : KIND_UNUSED;
            time_base += $urandom_range(0, 30000000);
            if (k == KIND_MATCH && $urandom_range(0, 1))
                add_item(k, STAMP_W'({$urandom, $urandom}), rand_dist(), rand_dist());
            else
                add_item(k, STAMP_W'(time_base + $urandom_range(0, 60000000)),
                         rand_dist(), rand_dist());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty match, unused kind, full store, tie and extremes
        add_item(KIND_MATCH, '0, 0, 0);
        add_item(KIND_UNUSED, '1, -1, -1);
        for (int i = 0; i <= DEPTH; i++)
            add_item(KIND_CAMERA, 1000 + i, (i % 3 == 0) ? -32768 : 32767, i * 10 - 50);
        add_item(KIND_LIDAR, 1000, 32767, 0);
        add_item(KIND_MATCH, '0, 0, 0);
        add_item(KIND_LIDAR, 1001, -5, 7);
        add_item(KIND_MATCH, '0, 0, 0);
        add_item(KIND_MATCH, '0, 0, 0);
        flush_stores();

        write_reg(REG_DISCARD_AGE, CFG_MAX);
        write_reg(REG_MATCH_WINDOW, CFG_MAX);
        add_item(KIND_CAMERA, {STAMP_W{1'b1}}, 32767, 0);
        add_item(KIND_LIDAR, {STAMP_W{1'b1}}, 32767, -32768);
        add_item(KIND_MATCH, '0, 0, 0);
        add_item(KIND_CAMERA, 0, 1, 1);
        add_item(KIND_LIDAR, 0, 0, 2);
        add_item(KIND_MATCH, '0, 0, 0);

        // random phases over several register settings
        for (int ph = 0; ph < 5; ph++) begin
            flush_stores();
            case (ph)
                0: begin
                    write_reg(REG_DISCARD_AGE, DISCARD_AGE_RST);
                    write_reg(REG_MATCH_WINDOW, MATCH_WINDOW_RST);
                end
                1: begin
                    write_reg(REG_DISCARD_AGE, CFG_MAX);
                    write_reg(REG_MATCH_WINDOW, CFG_MAX);
                end
                2: begin
                    write_reg(REG_DISCARD_AGE, CFG_MAX);
                    write_reg(REG_MATCH_WINDOW, '0);
                end
                3: begin
                    write_reg(REG_DISCARD_AGE, 40'd200000000);
                    write_reg(REG_MATCH_WINDOW, 40'd80000000);
                end
                default: begin
                    write_reg(REG_DISCARD_AGE, 40'd300000000);
                    write_reg(REG_MATCH_WINDOW, 40'd1);
                end
            endcase
            time_base = (ph % 2) ? ({$urandom, $urandom} >> 2) : 64'd0;
            random_phase(100);
        end

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tspm_pkg.sv
hdl/tspm_ram.sv
hdl/tspm_sub.sv
hdl/two_sensor_timestamp_pair_merger_core.sv
verif/tb_two_sensor_timestamp_pair_merger_core.sv
